[sv/sxc_pkg.sv]
// Shared types, constants and character classes of the S-expression syntax checker.
package sxc_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int DEPTH_W     = 6;
	localparam int MAX_DEPTH   = 32;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

	// scan modes
	localparam logic [3:0] M_BASE     = 4'd0;
	localparam logic [3:0] M_TOKEN    = 4'd1;
	localparam logic [3:0] M_DIGITS   = 4'd2;
	localparam logic [3:0] M_QUOTED   = 4'd3;
	localparam logic [3:0] M_QESC     = 4'd4;
	localparam logic [3:0] M_QDIGITS  = 4'd5;
	localparam logic [3:0] M_QSKIP_LF = 4'd6;
	localparam logic [3:0] M_QSKIP_CR = 4'd7;
	localparam logic [3:0] M_HEX      = 4'd8;
	localparam logic [3:0] M_B64      = 4'd9;
	localparam logic [3:0] M_SKIP     = 4'd10;

	// result status codes
	localparam logic [3:0] ST_OK            = 4'd0;
	localparam logic [3:0] ST_BAD_AFTER_LEN = 4'd1;
	localparam logic [3:0] ST_TOO_SHORT     = 4'd2;
	localparam logic [3:0] ST_UNMATCHED     = 4'd3;
	localparam logic [3:0] ST_NOT_LIST      = 4'd4;
	localparam logic [3:0] ST_BAD_CHAR      = 4'd5;
	localparam logic [3:0] ST_BAD_ESCAPE    = 4'd6;
	localparam logic [3:0] ST_LEADING_ZERO  = 4'd7;
	localparam logic [3:0] ST_NESTED_HINT   = 4'd8;
	localparam logic [3:0] ST_PAREN_IN_HINT = 4'd9;
	localparam logic [3:0] ST_STRAY_CLOSE   = 4'd10;
	localparam logic [3:0] ST_RESERVED      = 4'd11;
	localparam logic [3:0] ST_TOO_DEEP      = 4'd12;

	typedef struct packed {
		logic [7:0] char_in;
		logic       first_byte;
		logic       last_byte;
	} sxc_in_t;

	typedef struct packed {
		logic [3:0]             status;
		logic [OFFSET_BITS-1:0] error_offset;
	} sxc_out_t;

	typedef struct packed {
		logic [3:0]             scan_mode;
		logic [OFFSET_BITS-1:0] length_accum;
		logic [OFFSET_BITS-1:0] skip_remaining;
		logic [DEPTH_W-1:0]     nest_depth;
		logic                   list_seen;
		logic                   hint_open;
		logic [OFFSET_BITS-1:0] byte_position;
		logic [OFFSET_BITS-1:0] marked_position;
		logic [1:0]             escape_digits_left;
		logic                   escape_is_hex;
		logic                   halted;
	} sxc_state_t;

	localparam sxc_state_t STATE_RESET = '{
		scan_mode:          M_BASE,
		length_accum:       '0,
		skip_remaining:     '0,
		nest_depth:         '0,
		list_seen:          1'b0,
		hint_open:          1'b0,
		byte_position:      '0,
		marked_position:    '0,
		escape_digits_left: 2'd0,
		escape_is_hex:      1'b0,
		halted:             1'b0
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= "0") && (c <= "7");
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	function automatic logic is_tokch(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || is_digit(c) ||
			(c == "-") || (c == ".") || (c == "/") || (c == "_") || (c == ":") ||
			(c == "*") || (c == "+") || (c == "=");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

endpackage

[sv/sxc_step.sv]
// Next-state and result logic for one byte of the S-expression syntax checker.
module sxc_step (
	input  sxc_pkg::sxc_in_t    item,
	input  sxc_pkg::sxc_state_t cur,
	output sxc_pkg::sxc_state_t nxt,
	output logic                emit,
	output sxc_pkg::sxc_out_t   result
);

	sxc_pkg::sxc_state_t                 st;
	logic [7:0]                          c;
	logic [sxc_pkg::OFFSET_BITS-1:0]     pos;
	logic [sxc_pkg::OFFSET_BITS-1:0]     eoff;
	logic [3:0]                          code;
	logic                                run_base;
	logic [sxc_pkg::OFFSET_BITS+3:0]     acc_x10;
	logic [7:0]                          want;
	logic [1:0]                          digits_dec;

	assign c = item.char_in;

	always_comb begin
		st = item.first_byte ? sxc_pkg::STATE_RESET : cur;
		pos = st.byte_position;
		nxt = st;
		eoff = pos;
		code = sxc_pkg::ST_OK;
		run_base = 1'b0;
		acc_x10 = ({4'b0, st.length_accum} << 3) + ({4'b0, st.length_accum} << 1)
			+ {{sxc_pkg::OFFSET_BITS{1'b0}}, c[3:0]};
		want = (st.scan_mode == sxc_pkg::M_QSKIP_LF) ? 8'd10 : 8'd13;
		digits_dec = st.escape_digits_left - 2'd1;

		unique case (st.scan_mode)
			sxc_pkg::M_TOKEN: begin
				if (!sxc_pkg::is_tokch(c)) begin
					nxt.scan_mode = sxc_pkg::M_BASE;
					run_base = 1'b1;
				end
			end
			sxc_pkg::M_DIGITS: begin
				if (sxc_pkg::is_digit(c)) begin
					nxt.length_accum = (acc_x10 > {4'b0, sxc_pkg::POS_MAX}) ? sxc_pkg::POS_MAX
						: acc_x10[sxc_pkg::OFFSET_BITS-1:0];
				end else if (c == ":") begin
					if (!st.list_seen) begin
						eoff = '0;
						code = sxc_pkg::ST_NOT_LIST;
					end else if (st.length_accum == sxc_pkg::POS_MAX) begin
						code = sxc_pkg::ST_TOO_SHORT;
					end else begin
						nxt.marked_position = pos;
						nxt.skip_remaining = st.length_accum;
						nxt.scan_mode = (st.length_accum != '0) ? sxc_pkg::M_SKIP
							: sxc_pkg::M_BASE;
					end
				end else if (c == "\"") begin
					nxt.scan_mode = sxc_pkg::M_QUOTED;
				end else if (c == "#") begin
					nxt.scan_mode = sxc_pkg::M_HEX;
				end else if (c == "|") begin
					nxt.scan_mode = sxc_pkg::M_B64;
				end else begin
					code = sxc_pkg::ST_BAD_AFTER_LEN;
				end
			end
			sxc_pkg::M_QUOTED: begin
				if (c == "\\") nxt.scan_mode = sxc_pkg::M_QESC;
				else if (c == "\"") nxt.scan_mode = sxc_pkg::M_BASE;
			end
			sxc_pkg::M_QESC: begin
				if ((c == "b") || (c == "t") || (c == "v") || (c == "n") || (c == "f") ||
					(c == "r") || (c == "\"") || (c == "'") || (c == "\\")) begin
					nxt.scan_mode = sxc_pkg::M_QUOTED;
				end else if (sxc_pkg::is_oct(c) || (c == "x")) begin
					nxt.escape_is_hex = (c == "x");
					nxt.escape_digits_left = 2'd2;
					nxt.marked_position = pos;
					nxt.scan_mode = sxc_pkg::M_QDIGITS;
				end else if (c == 8'd13) begin
					nxt.scan_mode = sxc_pkg::M_QSKIP_LF;
				end else if (c == 8'd10) begin
					nxt.scan_mode = sxc_pkg::M_QSKIP_CR;
				end else begin
					code = sxc_pkg::ST_BAD_ESCAPE;
				end
			end
			sxc_pkg::M_QDIGITS: begin
				if (!(st.escape_is_hex ? sxc_pkg::is_hex(c) : sxc_pkg::is_oct(c))) begin
					eoff = st.marked_position;
					code = sxc_pkg::ST_BAD_ESCAPE;
				end else begin
					nxt.escape_digits_left = digits_dec;
					if (digits_dec == 2'd0) nxt.scan_mode = sxc_pkg::M_QUOTED;
				end
			end
			sxc_pkg::M_QSKIP_LF, sxc_pkg::M_QSKIP_CR: begin
				nxt.scan_mode = sxc_pkg::M_QUOTED;
				if (c != want) begin
					if (c == "\\") nxt.scan_mode = sxc_pkg::M_QESC;
					else if (c == "\"") nxt.scan_mode = sxc_pkg::M_BASE;
				end
			end
			sxc_pkg::M_HEX: begin
				if (c == "#") nxt.scan_mode = sxc_pkg::M_BASE;
			end
			sxc_pkg::M_B64: begin
				if (c == "|") nxt.scan_mode = sxc_pkg::M_BASE;
			end
			sxc_pkg::M_SKIP: begin
				nxt.skip_remaining = (st.skip_remaining != '0) ? st.skip_remaining - 1'b1
					: st.skip_remaining;
				if (nxt.skip_remaining == '0) nxt.scan_mode = sxc_pkg::M_BASE;
			end
			default: begin
				nxt.scan_mode = sxc_pkg::M_BASE;
				run_base = 1'b1;
			end
		endcase

		if (run_base) begin
			priority if (c == "(") begin
				if (st.hint_open) code = sxc_pkg::ST_PAREN_IN_HINT;
				else if (st.nest_depth >= sxc_pkg::DEPTH_W'(sxc_pkg::MAX_DEPTH))
					code = sxc_pkg::ST_TOO_DEEP;
				else begin
					nxt.nest_depth = st.nest_depth + 1'b1;
					nxt.list_seen = 1'b1;
				end
			end else if (c == ")") begin
				if (st.hint_open) code = sxc_pkg::ST_PAREN_IN_HINT;
				else if (!st.list_seen) begin
					eoff = '0;
					code = sxc_pkg::ST_NOT_LIST;
				end else if (st.nest_depth == '0) code = sxc_pkg::ST_UNMATCHED;
				else nxt.nest_depth = st.nest_depth - 1'b1;
			end else if (c == "\"") begin
				nxt.scan_mode = sxc_pkg::M_QUOTED;
			end else if (c == "#") begin
				nxt.scan_mode = sxc_pkg::M_HEX;
			end else if (c == "|") begin
				nxt.scan_mode = sxc_pkg::M_B64;
			end else if (c == "[") begin
				if (st.hint_open) code = sxc_pkg::ST_NESTED_HINT;
				else nxt.hint_open = 1'b1;
			end else if (c == "]") begin
				if (!st.hint_open) code = sxc_pkg::ST_STRAY_CLOSE;
				else nxt.hint_open = 1'b0;
			end else if (sxc_pkg::is_digit(c)) begin
				if (c == "0") code = sxc_pkg::ST_LEADING_ZERO;
				else begin
					nxt.length_accum = {{(sxc_pkg::OFFSET_BITS-4){1'b0}}, c[3:0]};
					nxt.scan_mode = sxc_pkg::M_DIGITS;
				end
			end else if (sxc_pkg::is_tokch(c)) begin
				nxt.scan_mode = sxc_pkg::M_TOKEN;
			end else if (sxc_pkg::is_space(c)) begin
				nxt.scan_mode = sxc_pkg::M_BASE;
			end else if ((c == "{") || (c == "&") || (c == "\\")) begin
				code = sxc_pkg::ST_RESERVED;
			end else begin
				code = sxc_pkg::ST_BAD_CHAR;
			end
		end

		// end of buffer with raw data or an escape still pending
		if ((code == sxc_pkg::ST_OK) && item.last_byte) begin
			if ((nxt.scan_mode == sxc_pkg::M_SKIP) && (nxt.skip_remaining != '0)) begin
				code = sxc_pkg::ST_TOO_SHORT;
				eoff = nxt.marked_position;
			end else if (nxt.scan_mode == sxc_pkg::M_QDIGITS) begin
				code = sxc_pkg::ST_BAD_ESCAPE;
				eoff = nxt.marked_position;
			end
		end

		if (pos != sxc_pkg::POS_MAX) nxt.byte_position = pos + 1'b1;

		emit = (code != sxc_pkg::ST_OK) || item.last_byte;
		if (emit) nxt.halted = 1'b1;
		result.status = code;
		result.error_offset = (code != sxc_pkg::ST_OK) ? eoff : '0;

		// drop bytes after a reported result until the next buffer starts
		if (!item.first_byte && cur.halted) begin
			nxt = cur;
			emit = 1'b0;
		end
	end

endmodule

[sv/sexpression_syntax_checker.sv]
// Top level of the S-expression syntax checker: input stage, state and result register.
// A byte is captured in the input stage; its result is then loaded into the result register.
// Throughput: one byte per cycle unless a result waits; sxc_step logic is combinational.
// Zero or one result per byte: one on the first error or on the last byte of a buffer.
// Reset (arst_n low, asynchronous) empties both stages and returns the scanner to base mode.
// A byte with first_byte set restarts the check regardless of earlier state.
module sexpression_syntax_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  sxc_pkg::sxc_in_t   byte_data,
	output logic               result_valid,
	input  logic               result_ready,
	output sxc_pkg::sxc_out_t  result_data
);

	// input stage
	logic                valid_s1;
	sxc_pkg::sxc_in_t    item_s1;

	// scanner state and result register
	sxc_pkg::sxc_state_t state_q;
	sxc_pkg::sxc_state_t state_next;
	logic                result_valid_q;
	sxc_pkg::sxc_out_t   result_q;

	logic                emit;
	sxc_pkg::sxc_out_t   step_result;
	logic                advance;

	// Process the held byte whenever the result register can take a new transaction.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	// Take a new byte when the input stage is empty or drains this cycle.
	assign byte_ready = !valid_s1 || advance;

	sxc_step u_step (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_next),
		.emit   (emit),
		.result (step_result)
	);

	// Input stage: control bit under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_data;
		end
	end

	// Scanner state: advance only when the held byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sxc_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register: load on a reporting byte, clear once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

[sv/sxc_checker.sv]
// Port-level checks of the S-expression syntax checker and their binding.
module sxc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              byte_ready,
	input logic              result_valid,
	input logic              result_ready,
	input sxc_pkg::sxc_out_t result_data
);

	// an ok result never carries an offset
	a_ok_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_data.status == sxc_pkg::ST_OK)) |->
		(result_data.error_offset == '0))
		else $error("ok result with nonzero offset");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.status <= sxc_pkg::ST_TOO_DEEP))
		else $error("status code out of range");

	// input stalls only behind a result that waits to be taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (result_valid && !result_ready))
		else $error("input stalled without output backpressure");

	// a pending result transaction holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
		else $error("result changed while stalled");

endmodule

bind sexpression_syntax_checker sxc_checker u_sxc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_ready   (byte_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);
